>>> hw/rtl/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared types and constants of the grid component labeler.
// ----------------------------------------------------------------------------
package gcl_pkg;

    // Item kinds on the command port.
    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    // Reply kinds on the result port.
    localparam logic REPLY_RUN  = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_GAP  = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_COLS = 2'd2;

    // Field widths and reset values.
    localparam int GAP_W   = 16;
    localparam int DIMR_W  = 7;
    localparam int DIM_W   = 9;
    localparam int COUNT_W = 13;
    localparam int LABEL_W = 12;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd100;
    localparam logic [DIMR_W-1:0] ROWS_RESET = 7'd48;
    localparam logic [DIMR_W-1:0] COLS_RESET = 7'd64;

    // Neighbour offset along one axis.
    typedef enum logic [1:0] {
        OFF_NEG,
        OFF_ZERO,
        OFF_POS
    } offs_t;

    // Flood fill sequencer states.
    typedef enum logic [3:0] {
        F_IDLE,
        F_CLEAR,
        F_SCAN_RD,
        F_SCAN_CHK,
        F_POP,
        F_POP_WAIT,
        F_CUR_WAIT,
        F_NB_RD,
        F_NB_CHK
    } fill_state_t;

    // Status from the sequencer to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } fill_stat_t;

    // Row offset of neighbour number n, raster order, centre skipped.
    function automatic offs_t nb_dr(input logic [2:0] n);
        offs_t o;
        if (n < 3'd3)
            o = OFF_NEG;
        else if (n < 3'd5)
            o = OFF_ZERO;
        else
            o = OFF_POS;
        return o;
    endfunction

    // Column offset of neighbour number n.
    function automatic offs_t nb_dc(input logic [2:0] n);
        offs_t o;
        case (n)
            3'd0, 3'd3, 3'd5: o = OFF_NEG;
            3'd1, 3'd6:       o = OFF_ZERO;
            default:          o = OFF_POS;
        endcase
        return o;
    endfunction

endpackage

>>> hw/rtl/gcl_ram.sv
// ----------------------------------------------------------------------------
// gcl_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module gcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/gcl_fill.sv
// ----------------------------------------------------------------------------
// gcl_fill
// Labeling sequencer: clears the label memory, scans the grid in raster order
// and flood-fills each new region through a queue memory.
// ----------------------------------------------------------------------------
module gcl_fill
    import gcl_pkg::*;
#(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int FRAME_BITS = 16,
    localparam int CELLS     = MAX_ROWS * MAX_COLS,
    localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start_run,
    input  logic [DIM_W-1:0]        rows_eff,
    input  logic [DIM_W-1:0]        cols_eff,
    input  logic [GAP_W-1:0]        gap,
    input  logic [FRAME_BITS:0]     cell_rdata,
    input  logic [LABEL_W:0]        lab_rdata,
    output fill_stat_t              stat,
    output logic [COUNT_W-1:0]      region_count,
    output logic [AW-1:0]           rd_addr,
    output logic                    lab_we,
    output logic [AW-1:0]           lab_waddr,
    output logic [LABEL_W:0]        lab_wdata
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int QW = AW + 1;
    localparam int DW = (FRAME_BITS > GAP_W) ? FRAME_BITS : GAP_W;

    fill_state_t            state_reg, state_next;
    logic                   run_reg, run_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [RW-1:0]          sr_reg, sr_next;
    logic [CW-1:0]          sc_reg, sc_next;
    logic [QW-1:0]          head_reg, head_next;
    logic [QW-1:0]          tail_reg, tail_next;
    logic [RW-1:0]          cur_r_reg, cur_r_next;
    logic [CW-1:0]          cur_c_reg, cur_c_next;
    logic [FRAME_BITS-1:0]  cur_frame_reg, cur_frame_next;
    logic [2:0]             nb_reg, nb_next;
    logic [RW-1:0]          n_r_reg, n_r_next;
    logic [CW-1:0]          n_c_reg, n_c_next;
    logic [COUNT_W-1:0]     region_reg, region_next;
    logic                   done_reg, done_next;

    logic                   q_we;
    logic [AW-1:0]          q_waddr;
    logic [AW-1:0]          q_raddr;
    logic [RW+CW-1:0]       q_wdata;
    logic [RW+CW-1:0]       q_rdata;

    logic                   scan_last_col;
    logic                   scan_last;
    logic                   empty_grid;
    logic                   q_nonempty;
    logic                   cell_used;
    logic [FRAME_BITS-1:0]  cell_frame;
    logic                   cell_labeled;
    logic [FRAME_BITS-1:0]  frame_diff;
    logic                   frames_close;
    logic                   seed_found;
    logic                   joins;
    logic                   nr_ok, nc_ok;
    logic [RW-1:0]          nr;
    logic [CW-1:0]          nc;
    logic [RW-1:0]          q_row;
    logic [CW-1:0]          q_col;

    // Flat memory address of a grid cell.
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    // Fill queue memory, holding row and column of each queued cell.
    gcl_ram #(
        .WIDTH (RW + CW),
        .DEPTH (CELLS)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // Decoded memory words and scan position flags.
    assign cell_used     = cell_rdata[FRAME_BITS];
    assign cell_frame    = cell_rdata[FRAME_BITS-1:0];
    assign cell_labeled  = lab_rdata[LABEL_W];
    assign frame_diff    = (cell_frame > cur_frame_reg) ? cell_frame - cur_frame_reg
                                                        : cur_frame_reg - cell_frame;
    assign frames_close  = DW'(frame_diff) <= DW'(gap);
    assign seed_found    = cell_used && !cell_labeled;
    assign joins         = cell_used && !cell_labeled && frames_close;
    assign scan_last_col = (DIM_W'(sc_reg) + DIM_W'(1)) == cols_eff;
    assign scan_last     = scan_last_col && ((DIM_W'(sr_reg) + DIM_W'(1)) == rows_eff);
    assign empty_grid    = (rows_eff == '0) || (cols_eff == '0);
    assign q_nonempty    = head_reg < tail_reg;
    assign q_row         = q_rdata[RW+CW-1:CW];
    assign q_col         = q_rdata[CW-1:0];

    // Neighbour coordinates and bounds.
    always_comb
    begin
        nr_ok = 1'b1;
        nr    = cur_r_reg;
        case (nb_dr(nb_reg))
            OFF_NEG:
            begin
                nr_ok = cur_r_reg != '0;
                nr    = cur_r_reg - RW'(1);
            end
            OFF_POS:
            begin
                nr_ok = (DIM_W'(cur_r_reg) + DIM_W'(1)) < rows_eff;
                nr    = cur_r_reg + RW'(1);
            end
            default:
            begin
                nr_ok = 1'b1;
                nr    = cur_r_reg;
            end
        endcase
        nc_ok = 1'b1;
        nc    = cur_c_reg;
        case (nb_dc(nb_reg))
            OFF_NEG:
            begin
                nc_ok = cur_c_reg != '0;
                nc    = cur_c_reg - CW'(1);
            end
            OFF_POS:
            begin
                nc_ok = (DIM_W'(cur_c_reg) + DIM_W'(1)) < cols_eff;
                nc    = cur_c_reg + CW'(1);
            end
            default:
            begin
                nc_ok = 1'b1;
                nc    = cur_c_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start_run)
                    state_next = F_CLEAR;
            end
            F_CLEAR:
            begin
                if (clr_reg == AW'(CELLS - 1))
                    state_next = (run_reg && !empty_grid) ? F_SCAN_RD : F_IDLE;
            end
            F_SCAN_RD:
                state_next = F_SCAN_CHK;
            F_SCAN_CHK:
            begin
                if (seed_found)
                    state_next = F_POP;
                else
                    state_next = scan_last ? F_IDLE : F_SCAN_RD;
            end
            F_POP:
            begin
                if (q_nonempty)
                    state_next = F_POP_WAIT;
                else
                    state_next = scan_last ? F_IDLE : F_SCAN_RD;
            end
            F_POP_WAIT:
                state_next = F_CUR_WAIT;
            F_CUR_WAIT:
                state_next = F_NB_RD;
            F_NB_RD:
            begin
                if (nr_ok && nc_ok)
                    state_next = F_NB_CHK;
                else if (nb_reg == 3'd7)
                    state_next = F_POP;
            end
            F_NB_CHK:
                state_next = (nb_reg == 3'd7) ? F_POP : F_NB_RD;
            default:
                state_next = F_IDLE;
        endcase
    end

    // Datapath updates and memory accesses per state.
    always_comb
    begin
        run_next       = run_reg;
        clr_next       = clr_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        cur_frame_next = cur_frame_reg;
        nb_next        = nb_reg;
        n_r_next       = n_r_reg;
        n_c_next       = n_c_reg;
        region_next    = region_reg;
        done_next      = 1'b0;
        rd_addr        = cell_addr(sr_reg, sc_reg);
        lab_we         = 1'b0;
        lab_waddr      = clr_reg;
        lab_wdata      = '0;
        q_we           = 1'b0;
        q_waddr        = tail_reg[AW-1:0];
        q_wdata        = {n_r_reg, n_c_reg};
        q_raddr        = head_reg[AW-1:0];
        unique case (state_reg)
            F_IDLE:
            begin
                if (start_run)
                begin
                    run_next    = 1'b1;
                    clr_next    = '0;
                    region_next = '0;
                end
            end
            F_CLEAR:
            begin
                lab_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1))
                begin
                    run_next  = 1'b0;
                    sr_next   = '0;
                    sc_next   = '0;
                    done_next = run_reg && empty_grid;
                end
            end
            F_SCAN_RD:
                rd_addr = cell_addr(sr_reg, sc_reg);
            F_SCAN_CHK:
            begin
                if (seed_found)
                begin
                    lab_we    = 1'b1;
                    lab_waddr = cell_addr(sr_reg, sc_reg);
                    lab_wdata = {1'b1, region_reg[LABEL_W-1:0]};
                    q_we      = 1'b1;
                    q_waddr   = '0;
                    q_wdata   = {sr_reg, sc_reg};
                    head_next = '0;
                    tail_next = QW'(1);
                end
                else
                begin
                    done_next = scan_last;
                    if (scan_last_col)
                    begin
                        sc_next = '0;
                        sr_next = sr_reg + RW'(1);
                    end
                    else
                    begin
                        sc_next = sc_reg + CW'(1);
                    end
                end
            end
            F_POP:
            begin
                if (q_nonempty)
                begin
                    q_raddr   = head_reg[AW-1:0];
                    head_next = head_reg + QW'(1);
                end
                else
                begin
                    region_next = region_reg + COUNT_W'(1);
                    done_next   = scan_last;
                    if (scan_last_col)
                    begin
                        sc_next = '0;
                        sr_next = sr_reg + RW'(1);
                    end
                    else
                    begin
                        sc_next = sc_reg + CW'(1);
                    end
                end
            end
            F_POP_WAIT:
            begin
                cur_r_next = q_row;
                cur_c_next = q_col;
                rd_addr    = cell_addr(q_row, q_col);
            end
            F_CUR_WAIT:
            begin
                cur_frame_next = cell_frame;
                nb_next        = '0;
            end
            F_NB_RD:
            begin
                if (nr_ok && nc_ok)
                begin
                    rd_addr  = cell_addr(nr, nc);
                    n_r_next = nr;
                    n_c_next = nc;
                end
                else
                begin
                    nb_next = nb_reg + 3'd1;
                end
            end
            F_NB_CHK:
            begin
                if (joins)
                begin
                    lab_we    = 1'b1;
                    lab_waddr = cell_addr(n_r_reg, n_c_reg);
                    lab_wdata = {1'b1, region_reg[LABEL_W-1:0]};
                    q_we      = 1'b1;
                    tail_next = tail_reg + QW'(1);
                end
                nb_next = nb_reg + 3'd1;
            end
            default:
            begin
                run_next = 1'b0;
            end
        endcase
    end

    // Control registers; the clearing pass starts straight out of reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_CLEAR;
            run_reg    <= 1'b0;
            clr_reg    <= '0;
            sr_reg     <= '0;
            sc_reg     <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            nb_reg     <= '0;
            region_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            run_reg    <= run_next;
            clr_reg    <= clr_next;
            sr_reg     <= sr_next;
            sc_reg     <= sc_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            nb_reg     <= nb_next;
            region_reg <= region_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers of the current and neighbouring cell.
    always_ff @(posedge clk)
    begin
        cur_r_reg     <= cur_r_next;
        cur_c_reg     <= cur_c_next;
        cur_frame_reg <= cur_frame_next;
        n_r_reg       <= n_r_next;
        n_c_reg       <= n_c_next;
    end

    assign stat.busy    = state_reg != F_IDLE;
    assign stat.done    = done_reg;
    assign region_count = region_reg;

endmodule

>>> hw/rtl/grid_component_labeler_top.sv
// ----------------------------------------------------------------------------
// grid_component_labeler_top
// Labels 8-connected regions of used cells whose starting frames lie within
// a gap limit, and answers label reads for single cells.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | word
//  ----------+---------------------------+------------------------------------
//  command   | start & !busy             | kind, cell_row, cell_col,
//            |                           | cell_used, start_frame
//  result    | done (one-cycle strobe)   | reply_kind, region_count,
//            |                           | region_label, has_label
//  config    | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
//  A load writes the cell memory when accepted. A read's reply shows in the
//  cycle after acceptance, set by the registered read of the label memory.
//  A run clears the label memory, then scans the cells and flood-fills each
//  new region; scan and fill share the single read port of the cell memory.
//  busy is high throughout. After reset a clearing pass keeps busy high.
//  The receiver cannot stall results; cfg_ready is always high.
// ----------------------------------------------------------------------------
module grid_component_labeler_top
    import gcl_pkg::*;
#(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int FRAME_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          kind,
    input  logic [5:0]          cell_row,
    input  logic [5:0]          cell_col,
    input  logic                cell_used,
    input  logic [15:0]         start_frame,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                done,
    output logic                reply_kind,
    output logic [COUNT_W-1:0]  region_count,
    output logic [LABEL_W-1:0]  region_label,
    output logic                has_label
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [GAP_W-1:0]       gap_reg;
    logic [DIMR_W-1:0]      rows_reg;
    logic [DIMR_W-1:0]      cols_reg;
    logic [DIM_W-1:0]       rows_eff;
    logic [DIM_W-1:0]       cols_eff;
    logic                   accept;
    logic                   in_grid;
    logic [AW-1:0]          item_addr;
    logic                   cell_we;
    logic [FRAME_BITS:0]    cell_wdata;
    logic [FRAME_BITS:0]    cell_rdata;
    logic [LABEL_W:0]       lab_rdata;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          fill_rd_addr;
    logic                   lab_we;
    logic [AW-1:0]          lab_waddr;
    logic [LABEL_W:0]       lab_wdata;
    fill_stat_t             stat;
    logic                   rd_pend_reg;
    logic                   rd_inside_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg  <= GAP_RESET;
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAP:  gap_reg  <= cfg_data;
                REG_ROWS: rows_reg <= cfg_data[DIMR_W-1:0];
                REG_COLS: cols_reg <= cfg_data[DIMR_W-1:0];
                default:  ;
            endcase
        end
    end

    // Grid size limited to capacity.
    assign rows_eff = (DIM_W'(rows_reg) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                            : DIM_W'(rows_reg);
    assign cols_eff = (DIM_W'(cols_reg) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                            : DIM_W'(cols_reg);

    // Command decode.
    assign accept    = start && !busy;
    assign in_grid   = (DIM_W'(cell_row) < rows_eff) && (DIM_W'(cell_col) < cols_eff);
    assign item_addr = AW'(32'(cell_row) * MAX_COLS + 32'(cell_col));
    assign cell_we   = accept && (kind == KIND_LOAD) && in_grid;
    assign cell_wdata = {cell_used, FRAME_BITS'(start_frame)};
    assign rd_addr   = stat.busy ? fill_rd_addr : item_addr;

    // Cell memory: used flag over starting frame.
    gcl_ram #(
        .WIDTH (FRAME_BITS + 1),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (cell_we),
        .waddr (item_addr),
        .wdata (cell_wdata),
        .raddr (rd_addr),
        .rdata (cell_rdata)
    );

    // Label memory: labeled flag over region label.
    gcl_ram #(
        .WIDTH (LABEL_W + 1),
        .DEPTH (CELLS)
    ) u_labels (
        .clk   (clk),
        .we    (lab_we),
        .waddr (lab_waddr),
        .wdata (lab_wdata),
        .raddr (rd_addr),
        .rdata (lab_rdata)
    );

    // Labeling sequencer.
    gcl_fill #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .FRAME_BITS (FRAME_BITS)
    ) u_fill (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_run    (accept && (kind == KIND_RUN)),
        .rows_eff     (rows_eff),
        .cols_eff     (cols_eff),
        .gap          (gap_reg),
        .cell_rdata   (cell_rdata),
        .lab_rdata    (lab_rdata),
        .stat         (stat),
        .region_count (region_count),
        .rd_addr      (fill_rd_addr),
        .lab_we       (lab_we),
        .lab_waddr    (lab_waddr),
        .lab_wdata    (lab_wdata)
    );

    // Read reply flag, registered so that it lines up with the label memory read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= accept && (kind == KIND_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_inside_reg <= in_grid;
    end

    // Result word.
    assign busy         = stat.busy;
    assign done         = rd_pend_reg || stat.done;
    assign reply_kind   = rd_pend_reg ? REPLY_READ : REPLY_RUN;
    assign has_label    = rd_pend_reg && rd_inside_reg && lab_rdata[LABEL_W];
    assign region_label = has_label ? lab_rdata[LABEL_W-1:0] : '0;

endmodule

>>> hw/rtl/gcl_check.sv
// ----------------------------------------------------------------------------
// gcl_check
// Port-level checks of the grid component labeler, bound to the top level.
// ----------------------------------------------------------------------------
module gcl_check
    import gcl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [1:0]          kind,
    input logic                done,
    input logic                reply_kind,
    input logic [COUNT_W-1:0]  region_count,
    input logic [LABEL_W-1:0]  region_label,
    input logic                has_label
);

    // No result word appears while a run is still in progress.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    // An accepted run keeps the block busy in the following cycle.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_RUN) |=> busy)
        else $error("run not started");

    // An accepted read is answered in the next cycle.
    a_read_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_READ) |=> (done && reply_kind == REPLY_READ))
        else $error("read reply missing");

    // A loaded cell gives no result word.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_LOAD) |=> !done)
        else $error("result word after load");

    // Run results carry no label.
    a_run_nolabel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && reply_kind == REPLY_RUN) |-> (!has_label && region_label == '0))
        else $error("label on run result");

endmodule

bind grid_component_labeler_top gcl_check u_check (.*);
